@@ src/pps_pkg.sv @@
// pps_pkg: shared types and constants for the preemptive priority scheduler
// holds the transaction kind codes, sequencer states, task entry layout and scan control
// no dependencies
package pps_pkg;

    // transaction kinds on the command port
    localparam logic [1:0] KIND_LOAD  = 2'd0;
    localparam logic [1:0] KIND_TICK  = 2'd1;
    localparam logic [1:0] KIND_CLEAR = 2'd2;

    localparam int unsigned FIELD_TIME_BITS = 16;
    localparam int unsigned FIELD_PRIO_BITS = 8;
    localparam int unsigned SLOT_BITS       = 4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_PICK,
        ST_COMMIT
    } state_t;

    // one task slot as stored in the table memory
    typedef struct packed {
        logic [FIELD_TIME_BITS-1:0] arrival;
        logic [FIELD_TIME_BITS-1:0] burst;
        logic [FIELD_PRIO_BITS-1:0] prio;
        logic [FIELD_TIME_BITS-1:0] remain;
    } task_entry_t;

    // control from the sequencer to the selection unit
    typedef struct packed {
        logic init;
        logic eval;
    } scan_ctl_t;

endpackage

@@ src/pps_ram.sv @@
// pps_ram: generic single write port, single read port ram with registered read
// no dependencies
module pps_ram #(
    parameter int WIDTH = 56,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

@@ src/pps_select.sv @@
// pps_select: shared readiness and priority compare unit, one slot per cycle
// keeps the best ready candidate and the running task's entry seen during a scan
// depends on pps_pkg
module pps_select #(
    parameter int IDXW      = 4,
    parameter int TIME_BITS = 16
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  pps_pkg::scan_ctl_t   ctl,
    input  logic [IDXW-1:0]      eval_idx,
    input  logic                 eval_live,
    input  pps_pkg::task_entry_t eval_entry,
    input  logic [TIME_BITS-1:0] clock_now,
    input  logic [IDXW-1:0]      cur_slot,
    input  logic                 cur_valid,
    output logic                 best_found,
    output logic [IDXW-1:0]      best_idx,
    output pps_pkg::task_entry_t best_entry,
    output logic                 cur_ready,
    output pps_pkg::task_entry_t cur_entry
);

    import pps_pkg::*;

    localparam int CMPW = (TIME_BITS > FIELD_TIME_BITS) ? TIME_BITS : FIELD_TIME_BITS;

    logic            best_found_reg, best_found_next;
    logic [IDXW-1:0] best_idx_reg, best_idx_next;
    task_entry_t     best_entry_reg, best_entry_next;
    logic            cur_ready_reg, cur_ready_next;
    task_entry_t     cur_entry_reg, cur_entry_next;
    logic            ready;
    logic            better;

    // live, arrived and work left
    assign ready = eval_live && (eval_entry.remain != '0) &&
                   (CMPW'(eval_entry.arrival) <= CMPW'(clock_now));

    // smaller priority, then earlier arrival; lower slot wins by scan order
    assign better = !best_found_reg ||
                    (eval_entry.prio < best_entry_reg.prio) ||
                    ((eval_entry.prio == best_entry_reg.prio) &&
                     (eval_entry.arrival < best_entry_reg.arrival));

    always_comb
    begin
        best_found_next = best_found_reg;
        best_idx_next   = best_idx_reg;
        best_entry_next = best_entry_reg;
        cur_ready_next  = cur_ready_reg;
        cur_entry_next  = cur_entry_reg;
        if (ctl.init)
        begin
            best_found_next = 1'b0;
            cur_ready_next  = 1'b0;
        end
        else if (ctl.eval)
        begin
            if (ready && better)
            begin
                best_found_next = 1'b1;
                best_idx_next   = eval_idx;
                best_entry_next = eval_entry;
            end
            if (eval_idx == cur_slot)
            begin
                cur_ready_next = ready && cur_valid;
                cur_entry_next = eval_entry;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            best_found_reg <= 1'b0;
            cur_ready_reg  <= 1'b0;
        end
        else
        begin
            best_found_reg <= best_found_next;
            cur_ready_reg  <= cur_ready_next;
        end
    end

    always_ff @(posedge clk)
    begin
        best_idx_reg   <= best_idx_next;
        best_entry_reg <= best_entry_next;
        cur_entry_reg  <= cur_entry_next;
    end

    assign best_found = best_found_reg;
    assign best_idx   = best_idx_reg;
    assign best_entry = best_entry_reg;
    assign cur_ready  = cur_ready_reg;
    assign cur_entry  = cur_entry_reg;

endmodule

@@ src/preemptive_priority_scheduler.sv @@
// preemptive_priority_scheduler: top level, command port, sequencer and commit datapath
// uses pps_pkg, pps_ram for the task table and pps_select for the scan compare
//
//  channel   handshake                  payload
//  --------  -------------------------  ----------------------------------------------
//  command   start, busy (start & !busy) kind, slot, arrival_time, burst_length,
//                                        task_priority
//  result    done (one cycle strobe)     running_slot, idle, switched, tick_time,
//                                        finished, finish_time, wait_time
//
//  load and clear transactions complete at the accepting edge; busy stays low
//  a tick transaction keeps busy high through the SCAN, PICK and COMMIT states: the scan
//  makes one table read per cycle through the single ram read port, PICK picks the
//  winner and COMMIT writes it back; done pulses as busy falls
//  reset clears the slot valid bits, clock and running task at once; the table memory
//  itself is never swept, an entry whose valid bit is clear reads as empty
//  the receiver cannot stall, so a result is shown exactly once
module preemptive_priority_scheduler #(
    parameter int SLOTS     = 16,
    parameter int TIME_BITS = 16
) (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    output logic                                    busy,
    input  logic [1:0]                              kind,
    input  logic [pps_pkg::SLOT_BITS-1:0]           slot,
    input  logic [pps_pkg::FIELD_TIME_BITS-1:0]     arrival_time,
    input  logic [pps_pkg::FIELD_TIME_BITS-1:0]     burst_length,
    input  logic [pps_pkg::FIELD_PRIO_BITS-1:0]     task_priority,
    output logic                                    done,
    output logic [pps_pkg::SLOT_BITS-1:0]           running_slot,
    output logic                                    idle,
    output logic                                    switched,
    output logic [pps_pkg::FIELD_TIME_BITS-1:0]     tick_time,
    output logic                                    finished,
    output logic [pps_pkg::FIELD_TIME_BITS-1:0]     finish_time,
    output logic [pps_pkg::FIELD_TIME_BITS-1:0]     wait_time
);

    import pps_pkg::*;

    localparam int IDXW  = $clog2(SLOTS);
    localparam int CW    = $clog2(SLOTS + 1);
    localparam int NEEDW = FIELD_TIME_BITS + 1;
    localparam int WW    = (TIME_BITS > NEEDW) ? TIME_BITS : NEEDW;

    // sequencer
    state_t state_reg, state_next;
    logic   accept;
    logic   tick_accept;
    logic   load_accept;
    logic   clear_accept;
    logic   scan_last;
    logic   issue_rd;

    // scan bookkeeping
    logic [CW-1:0]   scan_idx_reg, scan_idx_next;
    logic            eval_vld_reg, eval_vld_next;
    logic [IDXW-1:0] eval_idx_reg, eval_idx_next;

    // architectural state
    logic [TIME_BITS-1:0] clock_reg, clock_next;
    logic [IDXW-1:0]      cur_slot_reg, cur_slot_next;
    logic                 cur_valid_reg, cur_valid_next;
    logic [SLOTS-1:0]     live_reg, live_next;

    // winner of the scan
    logic                 pick_idle_reg, pick_idle_next;
    logic [IDXW-1:0]      pick_idx_reg, pick_idx_next;
    task_entry_t          pick_entry_reg, pick_entry_next;
    logic                 pick_switch_reg, pick_switch_next;
    logic [NEEDW-1:0]     need_reg, need_next;
    logic [TIME_BITS-1:0] fin_reg, fin_next;

    // result registers
    logic                       done_reg, done_next;
    logic [SLOT_BITS-1:0]       out_slot_reg, out_slot_next;
    logic                       out_idle_reg, out_idle_next;
    logic                       out_switch_reg, out_switch_next;
    logic [FIELD_TIME_BITS-1:0] out_tick_reg, out_tick_next;
    logic                       out_fin_reg, out_fin_next;
    logic [FIELD_TIME_BITS-1:0] out_fin_time_reg, out_fin_time_next;
    logic [FIELD_TIME_BITS-1:0] out_wait_reg, out_wait_next;

    // table memory ports
    logic            ram_we;
    logic [IDXW-1:0] ram_waddr;
    task_entry_t     ram_wdata;
    task_entry_t     ram_rdata;
    logic [IDXW-1:0] load_idx;
    logic            load_in_range;

    // selection unit
    scan_ctl_t   sel_ctl;
    logic        best_found;
    logic [IDXW-1:0] best_idx;
    task_entry_t best_entry;
    logic        cur_ready;
    task_entry_t cur_entry;
    logic        keep_cur;

    // commit arithmetic
    logic [FIELD_TIME_BITS-1:0] rem_dec;
    logic                       task_done;
    logic [WW-1:0]              fin_ext;
    logic [WW-1:0]              need_ext;
    logic [WW-1:0]              wait_diff;

    assign accept        = start && !busy;
    assign tick_accept   = accept && (kind == KIND_TICK);
    assign load_accept   = accept && (kind == KIND_LOAD);
    assign clear_accept  = accept && (kind == KIND_CLEAR);
    assign scan_last     = (scan_idx_reg == CW'(SLOTS));
    assign load_idx      = IDXW'(slot);
    assign load_in_range = (32'(slot) < SLOTS);

    // ---------------- next state ----------------
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_accept)
                begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (scan_last)
                begin
                    state_next = ST_PICK;
                end
            end
            ST_PICK:   state_next = ST_COMMIT;
            ST_COMMIT: state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // ---------------- sequencer outputs ----------------
    always_comb
    begin
        busy     = 1'b1;
        issue_rd = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                busy = 1'b0;
            end
            ST_SCAN:
            begin
                issue_rd = !scan_last;
            end
            ST_PICK:   busy = 1'b1;
            ST_COMMIT: busy = 1'b1;
            default:   busy = 1'b1;
        endcase
    end

    assign sel_ctl.init = tick_accept;
    assign sel_ctl.eval = eval_vld_reg;

    // ---------------- scan counter ----------------
    always_comb
    begin
        scan_idx_next = scan_idx_reg;
        eval_vld_next = issue_rd;
        eval_idx_next = eval_idx_reg;
        if (tick_accept)
        begin
            scan_idx_next = '0;
        end
        else if (issue_rd)
        begin
            scan_idx_next = scan_idx_reg + CW'(1);
            eval_idx_next = scan_idx_reg[IDXW-1:0];
        end
    end

    // ---------------- pick the winner ----------------
    // the running task holds on unless the best candidate has a strictly smaller value
    assign keep_cur = cur_ready && !(best_entry.prio < cur_entry.prio);

    always_comb
    begin
        pick_idle_next   = pick_idle_reg;
        pick_idx_next    = pick_idx_reg;
        pick_entry_next  = pick_entry_reg;
        pick_switch_next = pick_switch_reg;
        need_next        = need_reg;
        fin_next         = fin_reg;
        if (state_reg == ST_PICK)
        begin
            pick_idle_next   = !best_found;
            pick_idx_next    = keep_cur ? cur_slot_reg : best_idx;
            pick_entry_next  = keep_cur ? cur_entry : best_entry;
            pick_switch_next = !cur_valid_reg ||
                               (cur_slot_reg != (keep_cur ? cur_slot_reg : best_idx));
            need_next        = NEEDW'(pick_entry_next.arrival) +
                               NEEDW'(pick_entry_next.burst);
            fin_next         = clock_reg + TIME_BITS'(1);
        end
    end

    // ---------------- commit ----------------
    assign rem_dec   = pick_entry_reg.remain - FIELD_TIME_BITS'(1);
    assign task_done = (rem_dec == '0);
    assign fin_ext   = WW'(fin_reg);
    assign need_ext  = WW'(need_reg);
    assign wait_diff = fin_ext - need_ext;

    always_comb
    begin
        done_next         = 1'b0;
        out_slot_next     = out_slot_reg;
        out_idle_next     = out_idle_reg;
        out_switch_next   = out_switch_reg;
        out_tick_next     = out_tick_reg;
        out_fin_next      = out_fin_reg;
        out_fin_time_next = out_fin_time_reg;
        out_wait_next     = out_wait_reg;
        if (state_reg == ST_COMMIT)
        begin
            done_next         = 1'b1;
            out_idle_next     = pick_idle_reg;
            out_tick_next     = FIELD_TIME_BITS'(clock_reg);
            out_slot_next     = '0;
            out_switch_next   = 1'b0;
            out_fin_next      = 1'b0;
            out_fin_time_next = '0;
            out_wait_next     = '0;
            if (!pick_idle_reg)
            begin
                out_slot_next   = SLOT_BITS'(pick_idx_reg);
                out_switch_next = pick_switch_reg;
                if (task_done)
                begin
                    out_fin_next      = 1'b1;
                    out_fin_time_next = FIELD_TIME_BITS'(fin_reg);
                    if (fin_ext > need_ext)
                    begin
                        out_wait_next = FIELD_TIME_BITS'(wait_diff);
                    end
                end
            end
        end
    end

    // ---------------- architectural state ----------------
    always_comb
    begin
        clock_next     = clock_reg;
        cur_slot_next  = cur_slot_reg;
        cur_valid_next = cur_valid_reg;
        live_next      = live_reg;
        if (clear_accept)
        begin
            clock_next     = '0;
            cur_slot_next  = '0;
            cur_valid_next = 1'b0;
            live_next      = '0;
        end
        else if (load_accept && load_in_range)
        begin
            live_next[load_idx] = 1'b1;
        end
        else if (state_reg == ST_COMMIT)
        begin
            clock_next     = clock_reg + TIME_BITS'(1);
            cur_valid_next = !pick_idle_reg && !task_done;
            if (!pick_idle_reg)
            begin
                cur_slot_next = pick_idx_reg;
            end
        end
    end

    // table writes: a load fills the whole slot, a commit writes back the decremented work
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = load_idx;
        ram_wdata.arrival = arrival_time;
        ram_wdata.burst   = burst_length;
        ram_wdata.prio    = task_priority;
        ram_wdata.remain  = burst_length;
        if (load_accept && load_in_range)
        begin
            ram_we = 1'b1;
        end
        else if ((state_reg == ST_COMMIT) && !pick_idle_reg)
        begin
            ram_we           = 1'b1;
            ram_waddr        = pick_idx_reg;
            ram_wdata        = pick_entry_reg;
            ram_wdata.remain = rem_dec;
        end
    end

    // ---------------- registers ----------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            scan_idx_reg  <= '0;
            eval_vld_reg  <= 1'b0;
            clock_reg     <= '0;
            cur_slot_reg  <= '0;
            cur_valid_reg <= 1'b0;
            live_reg      <= '0;
            done_reg      <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scan_idx_reg  <= scan_idx_next;
            eval_vld_reg  <= eval_vld_next;
            clock_reg     <= clock_next;
            cur_slot_reg  <= cur_slot_next;
            cur_valid_reg <= cur_valid_next;
            live_reg      <= live_next;
            done_reg      <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        eval_idx_reg     <= eval_idx_next;
        pick_idle_reg    <= pick_idle_next;
        pick_idx_reg     <= pick_idx_next;
        pick_entry_reg   <= pick_entry_next;
        pick_switch_reg  <= pick_switch_next;
        need_reg         <= need_next;
        fin_reg          <= fin_next;
        out_slot_reg     <= out_slot_next;
        out_idle_reg     <= out_idle_next;
        out_switch_reg   <= out_switch_next;
        out_tick_reg     <= out_tick_next;
        out_fin_reg      <= out_fin_next;
        out_fin_time_reg <= out_fin_time_next;
        out_wait_reg     <= out_wait_next;
    end

    // ---------------- submodules ----------------
    pps_ram #(
        .WIDTH ($bits(task_entry_t)),
        .DEPTH (SLOTS)
    ) u_table (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_waddr),
        .wr_data (ram_wdata),
        .rd_en   (issue_rd),
        .rd_addr (scan_idx_reg[IDXW-1:0]),
        .rd_data (ram_rdata)
    );

    pps_select #(
        .IDXW      (IDXW),
        .TIME_BITS (TIME_BITS)
    ) u_select (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctl        (sel_ctl),
        .eval_idx   (eval_idx_reg),
        .eval_live  (live_reg[eval_idx_reg]),
        .eval_entry (ram_rdata),
        .clock_now  (clock_reg),
        .cur_slot   (cur_slot_reg),
        .cur_valid  (cur_valid_reg),
        .best_found (best_found),
        .best_idx   (best_idx),
        .best_entry (best_entry),
        .cur_ready  (cur_ready),
        .cur_entry  (cur_entry)
    );

    assign done         = done_reg;
    assign running_slot = out_slot_reg;
    assign idle         = out_idle_reg;
    assign switched     = out_switch_reg;
    assign tick_time    = out_tick_reg;
    assign finished     = out_fin_reg;
    assign finish_time  = out_fin_time_reg;
    assign wait_time    = out_wait_reg;

    // ---------------- assertions ----------------
    // a result only follows a commit step
    a_done_after_commit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(state_reg == ST_COMMIT))
        else $error("result strobe without a commit");

    // an accepted tick always starts a scan
    a_tick_starts_scan: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (kind == KIND_TICK)) |=> (state_reg == ST_SCAN))
        else $error("tick transaction did not start a scan");

    // a completed task releases the processor
    a_finish_releases: assert property (@(posedge clk) disable iff (!rst_n)
        (done && finished) |-> !cur_valid_reg)
        else $error("finished task still marked running");

    // an idle tick reports no switch and no completion
    a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (done && idle) |-> (!switched && !finished && !cur_valid_reg))
        else $error("idle tick reported task activity");

endmodule
